// ----- rtl/cfd_pkg.sv -----
// Package for the checksummed frame deframer: shared types, verdict codes,
// register indexes and frame layout constants. No dependencies.
`timescale 1ns / 1ps

package cfd_pkg;

    // Frame layout: start, command, length, payload, checksum, end marker.
    localparam int CNT_W          = 9;
    localparam int FRAME_OVERHEAD = 5;
    localparam int CMD_POS        = 2;
    localparam int LEN_POS        = 3;
    localparam int FIRST_PAY_POS  = 4;
    localparam int MAX_FRAME_LEN  = 260;

    localparam int DEF_MAX_FRAME_BYTES = 128;

    localparam int BYTE_W    = 8;
    localparam int CFG_IDX_W = 1;

    localparam logic [CFG_IDX_W-1:0] CFG_START_MARKER = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_END_MARKER   = 1'b1;

    localparam logic [BYTE_W-1:0] START_MARKER_RST = 8'hAA;
    localparam logic [BYTE_W-1:0] END_MARKER_RST   = 8'h55;

    typedef enum logic [2:0] {
        VERDICT_BUSY = 3'd0,
        VERDICT_GOOD = 3'd1,
        VERDICT_CSUM = 3'd2,
        VERDICT_END  = 3'd3,
        VERDICT_OVF  = 3'd4
    } t_verdict;

    typedef struct packed {
        logic [BYTE_W-1:0] start_marker;
        logic [BYTE_W-1:0] end_marker;
    } t_cfg;

    typedef struct packed {
        logic [BYTE_W-1:0] payload_length;
        logic [BYTE_W-1:0] frame_command;
        t_verdict          verdict;
        logic              last_of_frame;
        logic              first_of_frame;
        logic [BYTE_W-1:0] out_byte;
    } t_result;

endpackage

// ----- rtl/cfd_parser.sv -----
// Frame parser: holds the frame state and turns each byte of a frame, start marker included, into one result.
// Depends on cfd_pkg.
`timescale 1ns / 1ps

module cfd_parser #(
    parameter int MAX_FRAME_BYTES = cfd_pkg::DEF_MAX_FRAME_BYTES
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_step,
    input  logic [cfd_pkg::BYTE_W-1:0]  i_byte,
    input  cfd_pkg::t_cfg               i_cfg,
    output logic                        o_res_valid,
    output cfd_pkg::t_result            o_res
);
    import cfd_pkg::*;

    // Compare width wide enough for both the counter and the limit.
    localparam int LIM_W = $clog2(MAX_FRAME_BYTES + 1);
    localparam int CMP_W = (LIM_W > CNT_W) ? LIM_W : CNT_W;

    logic              r_in_frame, n_in_frame;
    logic [CNT_W-1:0]  r_cnt, n_cnt;
    logic [BYTE_W-1:0] r_cmd, n_cmd;
    logic [BYTE_W-1:0] r_len, n_len;
    logic [BYTE_W-1:0] r_sum, n_sum;
    logic [BYTE_W-1:0] r_prev, n_prev;

    logic [CNT_W-1:0]  w_n;
    logic              w_end;
    logic              w_add;
    logic              w_ovf;
    t_verdict          w_end_verdict;

    assign w_n   = r_cnt + CNT_W'(1);
    assign w_end = (w_n >= CNT_W'(FRAME_OVERHEAD))
                && (w_n == CNT_W'(r_len) + CNT_W'(FRAME_OVERHEAD));
    assign w_add = (w_n >= CNT_W'(FIRST_PAY_POS))
                && (w_n <= CNT_W'(r_len) + CNT_W'(LEN_POS));
    assign w_ovf = !w_end && (CMP_W'(w_n) >= CMP_W'(MAX_FRAME_BYTES));

    always_comb begin
        if (i_byte != i_cfg.end_marker) begin
            w_end_verdict = VERDICT_END;
        end else if (r_prev != r_sum) begin
            w_end_verdict = VERDICT_CSUM;
        end else begin
            w_end_verdict = VERDICT_GOOD;
        end
    end

    always_comb begin
        n_in_frame  = r_in_frame;
        n_cnt       = r_cnt;
        n_cmd       = r_cmd;
        n_len       = r_len;
        n_sum       = r_sum;
        n_prev      = r_prev;
        o_res_valid = 1'b0;
        o_res       = '0;

        if (i_step) begin
            if (!r_in_frame) begin
                if (i_byte == i_cfg.start_marker) begin
                    n_in_frame           = 1'b1;
                    n_cnt                = CNT_W'(1);
                    n_cmd                = '0;
                    n_len                = '0;
                    n_sum                = '0;
                    n_prev               = i_byte;
                    o_res_valid          = 1'b1;
                    o_res.first_of_frame = 1'b1;
                end
            end else begin
                n_cnt       = w_n;
                n_prev      = i_byte;
                o_res_valid = 1'b1;
                if (w_n == CNT_W'(CMD_POS)) begin
                    n_cmd = i_byte;
                    n_sum = i_byte;
                end else if (w_n == CNT_W'(LEN_POS)) begin
                    n_len = i_byte;
                end else if (w_end) begin
                    o_res.verdict       = w_end_verdict;
                    o_res.last_of_frame = 1'b1;
                    n_in_frame          = 1'b0;
                end
                if (w_add) begin
                    n_sum = r_sum + i_byte;
                end
                if (w_ovf) begin
                    o_res.verdict       = VERDICT_OVF;
                    o_res.last_of_frame = 1'b1;
                    n_in_frame          = 1'b0;
                end
            end
        end

        o_res.out_byte       = i_byte;
        o_res.frame_command  = n_cmd;
        o_res.payload_length = (n_cnt >= CNT_W'(LEN_POS)) ? n_len : '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_frame <= 1'b0;
            r_cnt      <= '0;
            r_cmd      <= '0;
            r_len      <= '0;
            r_sum      <= '0;
            r_prev     <= '0;
        end else begin
            r_in_frame <= n_in_frame;
            r_cnt      <= n_cnt;
            r_cmd      <= n_cmd;
            r_len      <= n_len;
            r_sum      <= n_sum;
            r_prev     <= n_prev;
        end
    end

`ifndef SYNTHESIS
    a_last_has_verdict: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid && o_res.last_of_frame |-> o_res.verdict != VERDICT_BUSY)
        else $error("final byte of a frame carries no verdict");

    a_first_from_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid && o_res.first_of_frame |-> !r_in_frame)
        else $error("frame opened while already inside a frame");

    a_close_to_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid && o_res.last_of_frame |=> !r_in_frame)
        else $error("parser stayed in a frame after its last byte");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_frame |-> (r_cnt >= CNT_W'(1)) && (r_cnt < CNT_W'(MAX_FRAME_LEN)))
        else $error("frame byte count out of range");
`endif

endmodule

// ----- rtl/cfd_out_reg.sv -----
// Result register of the deframer: holds one result word until it is taken.
// Depends on cfd_pkg.
`timescale 1ns / 1ps

module cfd_out_reg (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_load,
    input  cfd_pkg::t_result  i_res,
    input  logic              i_ready,
    output logic              o_can_load,
    output logic              o_valid,
    output cfd_pkg::t_result  o_res
);
    import cfd_pkg::*;

    logic    r_valid;
    t_result r_res;

    // The register frees up in the same cycle its word is taken.
    assign o_can_load = !r_valid || i_ready;
    assign o_valid    = r_valid;
    assign o_res      = r_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_can_load) begin
            r_valid <= i_load;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_can_load && i_load) begin
            r_res <= i_res;
        end
    end

endmodule

// ----- rtl/checksummed_frame_deframer.sv -----
// Checksummed frame deframer, top level: stream ports, configuration
// registers, input register, frame parser and result register.
// Depends on cfd_pkg, cfd_parser and cfd_out_reg.
// Path: an accepted word passes the input register, the parser and the result register.
// Throughput: one word per cycle while the output is ready; output back-pressure stalls the input.
// Reset: synchronous, active low; clears both pipeline registers and the frame
// state, and returns the markers to 0xAA (start) and 0x55 (end).
`timescale 1ns / 1ps

module checksummed_frame_deframer #(
    parameter int MAX_FRAME_BYTES = cfd_pkg::DEF_MAX_FRAME_BYTES
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // Configuration write port.
    input  logic                          i_cfg_we,
    input  logic [cfd_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [cfd_pkg::BYTE_W-1:0]    i_cfg_wdata,
    // Input stream.
    input  logic                          i_s_tvalid,
    output logic                          o_s_tready,
    input  logic [7:0]                    i_s_tdata,  // [7:0] rx_byte
    // Output stream.
    output logic                          o_m_tvalid,
    input  logic                          i_m_tready,
    // [7:0] out_byte, [15:8] frame_command, [23:16] payload_length
    output logic [23:0]                   o_m_tdata,
    output logic                          o_m_tlast,  // last_of_frame
    output logic [3:0]                    o_m_tuser   // [0] first_of_frame, [3:1] verdict
);
    import cfd_pkg::*;

    // Marker registers. They must only be written while the block is idle; the block itself does not enforce this.
    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.start_marker <= START_MARKER_RST;
            r_cfg.end_marker   <= END_MARKER_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_START_MARKER: r_cfg.start_marker <= i_cfg_wdata;
                CFG_END_MARKER:   r_cfg.end_marker   <= i_cfg_wdata;
                default:          r_cfg              <= r_cfg;
            endcase
        end
    end

    // Input register. A held word moves into the parser whenever the result
    // register can take a word. While a finished result waits downstream one
    // more word can still enter; after that the input stalls until the
    // result is taken.
    logic              r_in_valid;
    logic [BYTE_W-1:0] r_in_byte;
    logic              w_can_load;
    logic              w_step;
    logic              w_res_valid;
    t_result           w_res;
    logic              w_out_valid;
    t_result           w_out_res;

    assign w_step     = r_in_valid && w_can_load;
    assign o_s_tready = !r_in_valid || w_can_load;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_tready) begin
            r_in_valid <= i_s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_tready && i_s_tvalid) begin
            r_in_byte <= i_s_tdata[BYTE_W-1:0];
        end
    end

    // The parser updates its frame state only when it steps; a byte outside
    // a frame that is not the start marker steps it but yields no result.
    cfd_parser #(
        .MAX_FRAME_BYTES (MAX_FRAME_BYTES)
    ) u_parser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_step      (w_step),
        .i_byte      (r_in_byte),
        .i_cfg       (r_cfg),
        .o_res_valid (w_res_valid),
        .o_res       (w_res)
    );

    cfd_out_reg u_out_reg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (w_res_valid),
        .i_res      (w_res),
        .i_ready    (i_m_tready),
        .o_can_load (w_can_load),
        .o_valid    (w_out_valid),
        .o_res      (w_out_res)
    );

    assign o_m_tvalid = w_out_valid;
    assign o_m_tdata  = {w_out_res.payload_length, w_out_res.frame_command,
                         w_out_res.out_byte};
    assign o_m_tlast  = w_out_res.last_of_frame;
    assign o_m_tuser  = {w_out_res.verdict, w_out_res.first_of_frame};

endmodule

// ----- bench/tb_checksummed_frame_deframer.sv -----
// Self-checking testbench for checksummed_frame_deframer: streams marker-framed
// byte traffic through the block and checks every result word against a local model.
// Depends on cfd_pkg and the deframer RTL.
`timescale 1ns / 1ps

module tb_checksummed_frame_deframer;

    import cfd_pkg::*;

    localparam int FRAME_LIMIT    = DEF_MAX_FRAME_BYTES;
    localparam int SETTLE_CYCLES  = 6;     // settle time for the input and result registers
    localparam int WATCHDOG_LIMIT = 5000;  // well above the long receiver hold
    localparam int LONG_HOLD      = 400;
    localparam int PHASE_BUDGET   = 165;   // frame bytes of random traffic per phase

    typedef enum {FLAW_NONE, FLAW_SUM, FLAW_END, FLAW_BOTH} t_frame_flaw;

    // Clock and reset.
    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Block ports. All inputs start at known values.
    logic                 i_cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_idx   = CFG_START_MARKER;
    logic [BYTE_W-1:0]    i_cfg_wdata = '0;
    logic                 i_s_tvalid  = 1'b0;
    logic                 o_s_tready;
    logic [7:0]           i_s_tdata   = '0;   // [7:0] rx_byte
    logic                 o_m_tvalid;
    logic                 i_m_tready  = 1'b0;
    logic [23:0]          o_m_tdata;          // [7:0] out_byte, [15:8] command, [23:16] length
    logic                 o_m_tlast;          // last_of_frame
    logic [3:0]           o_m_tuser;          // [0] first_of_frame, [3:1] verdict

    checksummed_frame_deframer #(
        .MAX_FRAME_BYTES(FRAME_LIMIT)
    ) uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_wdata(i_cfg_wdata),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tlast  (o_m_tlast),
        .o_m_tuser  (o_m_tuser)
    );

    // ------------------------------------------------------------------
    // Local model of the deframer. The marker registers here mirror what
    // was written to the block; they only change while the block is idle.
    // ------------------------------------------------------------------
    logic [7:0] start_mk = START_MARKER_RST;
    logic [7:0] end_mk   = END_MARKER_RST;
    logic       frame_open = 1'b0;
    logic [8:0] frame_pos  = '0;
    logic [7:0] cur_cmd    = '0;
    logic [7:0] cur_len    = '0;
    logic [7:0] csum_acc   = '0;
    logic [7:0] last_byte  = '0;

    t_result    pending_results[$];   // expected result words, oldest first
    logic [7:0] rx_backlog[$];        // received bytes waiting to be driven

    // Bookkeeping shared by the driver, the sink and the checker.
    logic rx_taken       = 1'b0;
    logic quiet_tail     = 1'b0;
    logic long_hold_done = 1'b0;
    int   src_gap = 0, src_calm = 0;
    int   sink_gap = 0, sink_calm = 0, long_hold_left = 0;
    int   words_in = 0, results_seen = 0, mismatches = 0, idle_cycles = 0;
    int   marker_settings = 1;
    int   verdict_seen[0:7];

    initial foreach (verdict_seen[k]) verdict_seen[k] = 0;

    // Advance the model by one accepted byte and queue the word it produces, if any.
    task automatic deframe_byte(input logic [7:0] b);
        t_result    r;
        logic [8:0] n;
        r = '0;
        r.verdict  = VERDICT_BUSY;
        r.out_byte = b;
        if (!frame_open) begin
            // Outside a frame only the start marker matters; other bytes vanish.
            if (b != start_mk) return;
            frame_open = 1'b1;
            frame_pos  = 9'd1;
            cur_cmd    = '0;
            cur_len    = '0;
            csum_acc   = '0;
            r.first_of_frame = 1'b1;
        end else begin
            n = frame_pos + 9'd1;
            frame_pos = n;
            if (n == CMD_POS) begin
                cur_cmd  = b;
                csum_acc = b;
            end else if (n == LEN_POS) begin
                cur_len = b;
            end else if (n >= FRAME_OVERHEAD && int'(n) == int'(cur_len) + FRAME_OVERHEAD) begin
                // Closing byte: a bad end marker wins over a bad checksum.
                if (b != end_mk)
                    r.verdict = VERDICT_END;
                else if (last_byte != csum_acc)
                    r.verdict = VERDICT_CSUM;
                else
                    r.verdict = VERDICT_GOOD;
                r.last_of_frame = 1'b1;
                frame_open = 1'b0;
            end
            if (n >= FIRST_PAY_POS && int'(n) <= int'(cur_len) + LEN_POS)
                csum_acc = csum_acc + b;
            // The size limit aborts the frame unless it closed on this very byte.
            if (!r.last_of_frame && n >= FRAME_LIMIT) begin
                r.verdict       = VERDICT_OVF;
                r.last_of_frame = 1'b1;
                frame_open      = 1'b0;
            end
        end
        last_byte = b;
        r.frame_command  = cur_cmd;
        r.payload_length = (frame_pos >= LEN_POS) ? cur_len : 8'd0;
        pending_results.push_back(r);
    endtask

    task automatic check_field(input string name, input logic [7:0] want_v,
                               input logic [7:0] got_v);
        if (got_v !== want_v) begin
            $error("%s: expected %0d, got %0d", name, want_v, got_v);
            mismatches++;
        end
    endtask

    // ------------------------------------------------------------------
    // Rising edge: record accepted words on both sides, check results and
    // run the watchdog.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin : observe
        t_result got;
        t_result want;
        logic    moved;
        moved = i_cfg_we;
        if (i_rst_n) begin
            if (i_s_tvalid && o_s_tready) begin
                deframe_byte(i_s_tdata);
                rx_taken = 1'b1;
                words_in++;
                moved = 1'b1;
            end
            if (o_m_tvalid && i_m_tready) begin
                moved = 1'b1;
                results_seen++;
                got.out_byte       = o_m_tdata[7:0];
                got.frame_command  = o_m_tdata[15:8];
                got.payload_length = o_m_tdata[23:16];
                got.first_of_frame = o_m_tuser[0];
                got.verdict        = t_verdict'(o_m_tuser[3:1]);
                got.last_of_frame  = o_m_tlast;
                if (pending_results.size() == 0) begin
                    $error("result word 0x%h arrived with nothing expected", o_m_tdata);
                    mismatches++;
                end else begin
                    want = pending_results.pop_front();
                    check_field("out_byte", want.out_byte, got.out_byte);
                    check_field("first_of_frame", 8'(want.first_of_frame),
                                8'(got.first_of_frame));
                    check_field("last_of_frame", 8'(want.last_of_frame),
                                8'(got.last_of_frame));
                    check_field("verdict", 8'(want.verdict), 8'(got.verdict));
                    check_field("frame_command", want.frame_command, got.frame_command);
                    check_field("payload_length", want.payload_length, got.payload_length);
                end
                if (o_m_tlast === 1'b1) verdict_seen[o_m_tuser[3:1]]++;
            end
            if (moved) idle_cycles = 0;
            else idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("Timeout: no word moved for %0d cycles, %0d results outstanding",
                         idle_cycles, pending_results.size());
                $display("CHECK FAILED");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // Source driver. It holds a word until it is taken and inserts random
    // idle bursts, except inside calm stretches and in the quiet tail.
    // ------------------------------------------------------------------
    always @(negedge i_clk) begin : src_drive
        logic       vld;
        logic [7:0] dat;
        vld = i_s_tvalid;
        dat = i_s_tdata;
        if (rx_taken) begin
            rx_taken = 1'b0;
            vld = 1'b0;
        end
        if (i_rst_n && !vld) begin
            if (src_gap > 0) begin
                src_gap--;
            end else if (rx_backlog.size() > 0) begin
                if (!quiet_tail && src_calm == 0 && $urandom_range(0, 7) == 0) begin
                    src_gap = $urandom_range(0, 15);
                end else begin
                    vld = 1'b1;
                    dat = rx_backlog.pop_front();
                end
            end
        end
        if (src_calm > 0) src_calm--;
        else if ($urandom_range(0, 63) == 0) src_calm = $urandom_range(30, 150);
        i_s_tvalid <= vld;
        i_s_tdata  <= dat;
    end

    // ------------------------------------------------------------------
    // Result sink. Besides short random stalls it holds off once for a long
    // stretch so that the block backs up and stalls its input.
    // ------------------------------------------------------------------
    always @(negedge i_clk) begin : sink_drive
        logic rdy;
        rdy = 1'b1;
        if (!i_rst_n) begin
            rdy = 1'b0;
        end else if (long_hold_left > 0) begin
            long_hold_left--;
            rdy = 1'b0;
        end else if (!long_hold_done && results_seen >= 150) begin
            long_hold_done = 1'b1;
            long_hold_left = LONG_HOLD - 1;
            rdy = 1'b0;
        end else if (sink_gap > 0) begin
            sink_gap--;
            rdy = 1'b0;
        end else if (!quiet_tail && sink_calm == 0 && $urandom_range(0, 7) == 0) begin
            sink_gap = $urandom_range(0, 15);
            rdy = 1'b0;
        end
        if (sink_calm > 0) sink_calm--;
        else if ($urandom_range(0, 63) == 0) sink_calm = $urandom_range(30, 150);
        i_m_tready <= rdy;
    end

    // ------------------------------------------------------------------
    // Stimulus helpers.
    // ------------------------------------------------------------------
    function automatic logic [7:0] payload_byte();
        int pick;
        pick = $urandom_range(0, 19);
        // Now and then a marker value shows up as plain payload.
        if (pick == 0) return start_mk;
        if (pick == 1) return end_mk;
        return 8'($urandom_range(0, 255));
    endfunction

    // Queue one frame; the flaw spoils the checksum, the end marker or both.
    task automatic push_frame(input logic [7:0] cmd, input logic [7:0] len,
                              input t_frame_flaw flaw);
        logic [7:0] sum;
        logic [7:0] b;
        sum = cmd;
        rx_backlog.push_back(start_mk);
        rx_backlog.push_back(cmd);
        rx_backlog.push_back(len);
        for (int k = 0; k < len; k++) begin
            b = payload_byte();
            sum = sum + b;
            rx_backlog.push_back(b);
        end
        if (flaw == FLAW_SUM || flaw == FLAW_BOTH)
            sum = sum ^ 8'($urandom_range(1, 255));
        rx_backlog.push_back(sum);
        if (flaw == FLAW_END || flaw == FLAW_BOTH)
            rx_backlog.push_back(end_mk ^ 8'($urandom_range(1, 255)));
        else
            rx_backlog.push_back(end_mk);
    endtask

    // Mostly well-formed frames with random content, some with a bad checksum or
    // end marker, plus line noise and cut-short frames that swallow the next frame.
    task automatic random_traffic(input int budget);
        int          sent;
        int          pick;
        int          cut;
        logic [7:0]  len;
        t_frame_flaw flaw;
        sent = 0;
        while (sent < budget) begin
            pick = $urandom_range(0, 99);
            if (pick < 8) begin
                repeat ($urandom_range(1, 4)) rx_backlog.push_back(8'($urandom_range(0, 255)));
            end else if (pick < 15) begin
                cut = $urandom_range(0, 6);
                rx_backlog.push_back(start_mk);
                rx_backlog.push_back(8'($urandom_range(0, 255)));
                repeat (cut) rx_backlog.push_back(payload_byte());
                sent += cut + 2;
            end else begin
                len = ($urandom_range(0, 15) == 0) ? 8'($urandom_range(0, 255))
                                                   : 8'($urandom_range(0, 12));
                pick = $urandom_range(0, 19);
                flaw = (pick < 14) ? FLAW_NONE : (pick < 17) ? FLAW_SUM
                     : (pick < 19) ? FLAW_END : FLAW_BOTH;
                push_frame(8'($urandom_range(0, 255)), len, flaw);
                sent += int'(len) + FRAME_OVERHEAD;
            end
        end
    endtask

    // Let everything queued go through and every expected word come back.
    // The check repeats after the settle time so that a word the driver put
    // out in the same step as the first check is not missed.
    task automatic drain();
        do begin
            while (rx_backlog.size() != 0 || i_s_tvalid || pending_results.size() != 0)
                @(negedge i_clk);
            repeat (SETTLE_CYCLES) @(negedge i_clk);
        end while (rx_backlog.size() != 0 || i_s_tvalid || pending_results.size() != 0);
    endtask

    // End a phase with the block idle and outside any frame. A frame left
    // open is closed with filler; the size limit closes it at the latest.
    task automatic finish_phase();
        drain();
        if (frame_open) begin
            repeat (FRAME_LIMIT) rx_backlog.push_back(start_mk + 8'd1);
            drain();
        end
    endtask

    task automatic write_marker(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] val);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_idx   <= idx;
        i_cfg_wdata <= val;
        if (idx == CFG_START_MARKER) start_mk = val;
        else end_mk = val;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic set_markers(input logic [7:0] opener, input logic [7:0] closer);
        write_marker(CFG_START_MARKER, opener);
        write_marker(CFG_END_MARKER, closer);
        marker_settings++;
    endtask

    // ------------------------------------------------------------------
    // Test sequence.
    // ------------------------------------------------------------------
    initial begin : stimulus
        logic [7:0] same_mk;
        logic [7:0] directed[$];

        // Directed bytes under the reset markers: two idle bytes at the
        // extremes, a good empty frame, a checksum error whose payload is the
        // start marker, an end marker error with a correct checksum, and a
        // good frame whose checksum wraps past 255.
        directed = '{8'h00, 8'hFF,
                     START_MARKER_RST, 8'hFF, 8'h00, 8'hFF, END_MARKER_RST,
                     START_MARKER_RST, 8'h00, 8'h01, START_MARKER_RST, 8'h00, END_MARKER_RST,
                     START_MARKER_RST, 8'h12, 8'h00, 8'h12, 8'h00,
                     START_MARKER_RST, 8'hF0, 8'h02, 8'h20, 8'h05, 8'h15, END_MARKER_RST};

        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed[k]) rx_backlog.push_back(directed[k]);
        random_traffic(PHASE_BUDGET);
        finish_phase();

        // Extreme markers, plus frames that end exactly at the size limit
        // and one byte beyond it.
        set_markers(8'h00, 8'hFF);
        push_frame(8'($urandom_range(0, 255)), 8'(FRAME_LIMIT - FRAME_OVERHEAD), FLAW_NONE);
        push_frame(8'($urandom_range(0, 255)), 8'(FRAME_LIMIT - FRAME_OVERHEAD + 1), FLAW_NONE);
        random_traffic(PHASE_BUDGET);
        finish_phase();

        set_markers(8'hFF, 8'h00);
        random_traffic(PHASE_BUDGET);
        finish_phase();

        // One value opens and closes frames.
        same_mk = 8'($urandom_range(0, 255));
        set_markers(same_mk, same_mk);
        random_traffic(PHASE_BUDGET);
        finish_phase();

        // Last part runs at full rate on both sides.
        quiet_tail = 1'b1;
        set_markers(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
        random_traffic(PHASE_BUDGET);
        finish_phase();

        $display("Covered %0d input words and %0d result words over %0d marker settings.",
                 words_in, results_seen, marker_settings);
        $display("Frame endings: %0d good, %0d checksum, %0d end marker, %0d overflow.",
                 verdict_seen[VERDICT_GOOD], verdict_seen[VERDICT_CSUM],
                 verdict_seen[VERDICT_END], verdict_seen[VERDICT_OVF]);
        if (mismatches == 0 && pending_results.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
